/* rtl/core/tfn_pkg.sv */
`default_nettype none
package tfn_pkg;

    localparam int COORD_BITS       = 16;
    localparam int NORMAL_FRAC_BITS = 14;
    localparam int OUT_BITS         = NORMAL_FRAC_BITS + 2;
    // leading one of the largest cross magnitude is moved to this bit
    localparam int NORM_TOP         = 29;

    localparam int EDGE_W  = COORD_BITS + 1;
    localparam int CROSS_W = 2 * EDGE_W;
    localparam int MAG_W   = CROSS_W - 1;
    localparam int TOP_W   = $clog2(MAG_W);
    localparam int A_W     = NORM_TOP + 1;
    localparam int SQ_W    = 2 * A_W;
    localparam int SUM_W   = SQ_W + 2;
    localparam int ROOT_W  = SUM_W / 2;
    localparam int NUM_W   = ROOT_W + NORMAL_FRAC_BITS;
    localparam int QUO_W   = NORMAL_FRAC_BITS + 1;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] vertex0_x;
        logic signed [COORD_BITS-1:0] vertex0_y;
        logic signed [COORD_BITS-1:0] vertex0_z;
        logic signed [COORD_BITS-1:0] vertex1_x;
        logic signed [COORD_BITS-1:0] vertex1_y;
        logic signed [COORD_BITS-1:0] vertex1_z;
        logic signed [COORD_BITS-1:0] vertex2_x;
        logic signed [COORD_BITS-1:0] vertex2_y;
        logic signed [COORD_BITS-1:0] vertex2_z;
    } tfn_in_t;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] normal_x;
        logic signed [OUT_BITS-1:0] normal_y;
        logic signed [OUT_BITS-1:0] normal_z;
        logic                       degenerate;
    } tfn_out_t;

    typedef struct packed {
        logic signed [CROSS_W-1:0] cx;
        logic signed [CROSS_W-1:0] cy;
        logic signed [CROSS_W-1:0] cz;
    } tfn_cross_t;

    // normalised magnitudes with their signs
    typedef struct packed {
        logic [2:0][A_W-1:0] a;
        logic [2:0]          neg;
        logic                degen;
    } tfn_vec_t;

    typedef struct packed {
        logic [2:0][QUO_W-1:0] q;
        logic [2:0]            neg;
        logic                  degen;
    } tfn_quo_t;

endpackage
`default_nettype wire

/* rtl/core/triangle_face_normal_core.sv */
`default_nettype none
// channel   | ports                       | payload
// ----------+-----------------------------+-----------------------------
// input     | s_valid, s_ready, s_data    | three vertices, 16-bit coords
// result    | m_valid, m_ready, m_data    | Q1.14 unit normal, degenerate
//
// one triangle per cycle while m_ready does not stall; stages: edge/cross, normalise,
// root (one bit a stage), divide (one quotient bit a stage), output
// aresetn is synchronous and clears all valid bits; the data path is not reset
// the whole pipeline advances whenever the output register is empty or taken,
// so a stall at m_ready freezes every stage and loses or repeats no transfer
module triangle_face_normal_core (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire tfn_pkg::tfn_in_t  s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output tfn_pkg::tfn_out_t      m_data
);
    import tfn_pkg::*;

    logic       en;
    logic       cr_valid, nm_valid, sq_valid, dv_valid;
    tfn_cross_t cr_data;
    tfn_vec_t   nm_data, sq_data;
    tfn_quo_t   dv_data;
    logic [ROOT_W-1:0] sq_root;

    logic     m_valid_reg;
    tfn_out_t m_data_reg, m_data_next;
    logic [OUT_BITS-1:0] n_v [3];

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    tfn_cross u_cross (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(s_valid && s_ready), .in_data(s_data),
        .out_valid(cr_valid), .out_data(cr_data)
    );

    tfn_norm u_norm (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(cr_valid), .in_data(cr_data),
        .out_valid(nm_valid), .out_data(nm_data)
    );

    tfn_sqrt u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(nm_valid), .in_data(nm_data),
        .out_valid(sq_valid), .out_data(sq_data), .out_root(sq_root)
    );

    tfn_div u_div (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(sq_valid), .in_data(sq_data), .in_root(sq_root),
        .out_valid(dv_valid), .out_data(dv_data)
    );

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            if (dv_data.degen) begin
                n_v[j] = '0;
            end else if (dv_data.neg[j]) begin
                n_v[j] = OUT_BITS'(~{1'b0, dv_data.q[j]} + 1'b1);
            end else begin
                n_v[j] = {1'b0, dv_data.q[j]};
            end
        end
        m_data_next.normal_x   = n_v[0];
        m_data_next.normal_y   = n_v[1];
        m_data_next.normal_z   = n_v[2];
        m_data_next.degenerate = dv_data.degen;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    localparam logic signed [OUT_BITS-1:0] ONE_POS = OUT_BITS'(1) << NORMAL_FRAC_BITS;
    localparam logic signed [OUT_BITS-1:0] ONE_NEG = -ONE_POS;

    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.degenerate |->
            m_data.normal_x == '0 && m_data.normal_y == '0 && m_data.normal_z == '0)
        else $error("degenerate result with non-zero normal");

    a_unit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.normal_x <= ONE_POS && m_data.normal_x >= ONE_NEG
                 && m_data.normal_y <= ONE_POS && m_data.normal_y >= ONE_NEG
                 && m_data.normal_z <= ONE_POS && m_data.normal_z >= ONE_NEG)
        else $error("normal component beyond unit length");

    a_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.degenerate |->
            m_data.normal_x != '0 || m_data.normal_y != '0 || m_data.normal_z != '0)
        else $error("zero normal on a proper triangle");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid straight after reset");

endmodule
`default_nettype wire

/* rtl/core/tfn_cross.sv */
`default_nettype none
module tfn_cross (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                en,
    input  wire logic                in_valid,
    input  wire tfn_pkg::tfn_in_t    in_data,
    output logic                     out_valid,
    output tfn_pkg::tfn_cross_t      out_data
);
    import tfn_pkg::*;

    logic [2:0] vld_reg;

    logic signed [EDGE_W-1:0] ax_reg, ay_reg, az_reg, bx_reg, by_reg, bz_reg;
    logic signed [EDGE_W-1:0] ax_next, ay_next, az_next, bx_next, by_next, bz_next;
    logic signed [CROSS_W-1:0] p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    logic signed [CROSS_W-1:0] p0_next, p1_next, p2_next, p3_next, p4_next, p5_next;
    tfn_cross_t c_reg, c_next;

    always_comb begin
        ax_next = {in_data.vertex1_x[COORD_BITS-1], in_data.vertex1_x}
                - {in_data.vertex0_x[COORD_BITS-1], in_data.vertex0_x};
        ay_next = {in_data.vertex1_y[COORD_BITS-1], in_data.vertex1_y}
                - {in_data.vertex0_y[COORD_BITS-1], in_data.vertex0_y};
        az_next = {in_data.vertex1_z[COORD_BITS-1], in_data.vertex1_z}
                - {in_data.vertex0_z[COORD_BITS-1], in_data.vertex0_z};
        bx_next = {in_data.vertex2_x[COORD_BITS-1], in_data.vertex2_x}
                - {in_data.vertex0_x[COORD_BITS-1], in_data.vertex0_x};
        by_next = {in_data.vertex2_y[COORD_BITS-1], in_data.vertex2_y}
                - {in_data.vertex0_y[COORD_BITS-1], in_data.vertex0_y};
        bz_next = {in_data.vertex2_z[COORD_BITS-1], in_data.vertex2_z}
                - {in_data.vertex0_z[COORD_BITS-1], in_data.vertex0_z};
    end

    always_comb begin
        p0_next = ay_reg * bz_reg;
        p1_next = az_reg * by_reg;
        p2_next = az_reg * bx_reg;
        p3_next = ax_reg * bz_reg;
        p4_next = ax_reg * by_reg;
        p5_next = ay_reg * bx_reg;
    end

    always_comb begin
        c_next.cx = p0_reg - p1_reg;
        c_next.cy = p2_reg - p3_reg;
        c_next.cz = p4_reg - p5_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ax_reg <= ax_next;
            ay_reg <= ay_next;
            az_reg <= az_next;
            bx_reg <= bx_next;
            by_reg <= by_next;
            bz_reg <= bz_next;
            p0_reg <= p0_next;
            p1_reg <= p1_next;
            p2_reg <= p2_next;
            p3_reg <= p3_next;
            p4_reg <= p4_next;
            p5_reg <= p5_next;
            c_reg  <= c_next;
        end
    end

    assign out_valid = vld_reg[2];
    assign out_data  = c_reg;

endmodule
`default_nettype wire

/* rtl/core/tfn_norm.sv */
`default_nettype none
module tfn_norm (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                en,
    input  wire logic                in_valid,
    input  wire tfn_pkg::tfn_cross_t in_data,
    output logic                     out_valid,
    output tfn_pkg::tfn_vec_t        out_data
);
    import tfn_pkg::*;

    logic [2:0] vld_reg;

    logic [2:0][MAG_W-1:0] mag_reg, mag_next, mag2_reg;
    logic [2:0]            neg_reg, neg_next, neg2_reg;
    logic [TOP_W-1:0]      top_reg, top_next;
    logic                  degen_reg, degen_next;
    logic [MAG_W-1:0]      or_v;
    logic [MAG_W+NORM_TOP-1:0] wide [3];
    tfn_vec_t              vec_reg, vec_next;
    logic [CROSS_W-1:0]    c_v [3];

    always_comb begin
        c_v[0] = in_data.cx;
        c_v[1] = in_data.cy;
        c_v[2] = in_data.cz;
        for (int j = 0; j < 3; j++) begin
            neg_next[j] = c_v[j][CROSS_W-1];
            mag_next[j] = c_v[j][CROSS_W-1] ? MAG_W'(~c_v[j] + 1'b1) : c_v[j][MAG_W-1:0];
        end
    end

    // leading one of the or of the magnitudes is that of the largest one
    always_comb begin
        or_v     = mag_reg[0] | mag_reg[1] | mag_reg[2];
        top_next = '0;
        for (int b = 0; b < MAG_W; b++) begin
            if (or_v[b]) begin
                top_next = TOP_W'(b);
            end
        end
        degen_next = (or_v == '0);
    end

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            wide[j]        = {mag2_reg[j], {NORM_TOP{1'b0}}} >> top_reg;
            vec_next.a[j]  = wide[j][A_W-1:0];
        end
        vec_next.neg   = neg2_reg;
        vec_next.degen = degen_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_reg   <= mag_next;
            neg_reg   <= neg_next;
            mag2_reg  <= mag_reg;
            neg2_reg  <= neg_reg;
            top_reg   <= top_next;
            degen_reg <= degen_next;
            vec_reg   <= vec_next;
        end
    end

    assign out_valid = vld_reg[2];
    assign out_data  = vec_reg;

endmodule
`default_nettype wire

/* rtl/core/tfn_sqrt.sv */
`default_nettype none
module tfn_sqrt (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 en,
    input  wire logic                 in_valid,
    input  wire tfn_pkg::tfn_vec_t    in_data,
    output logic                      out_valid,
    output tfn_pkg::tfn_vec_t         out_data,
    output logic [tfn_pkg::ROOT_W-1:0] out_root
);
    import tfn_pkg::*;

    // stage 0 squares, stage 1 sum, then one root bit per stage
    localparam int NSTG = ROOT_W + 2;

    logic [NSTG-1:0] vld_reg;

    logic [2:0][SQ_W-1:0] sq_reg, sq_next;
    tfn_vec_t             sq_vec_reg;

    logic [SUM_W-1:0]  rem_reg  [ROOT_W+1];
    logic [ROOT_W-1:0] root_reg [ROOT_W+1];
    tfn_vec_t          vec_reg  [ROOT_W+1];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            sq_next[j] = in_data.a[j] * in_data.a[j];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NSTG-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_reg      <= sq_next;
            sq_vec_reg  <= in_data;
            rem_reg[0]  <= SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
            root_reg[0] <= '0;
            vec_reg[0]  <= sq_vec_reg;
        end
    end

    for (genvar i = 1; i <= ROOT_W; i++) begin : g_root
        localparam int K = ROOT_W - i;
        logic [SUM_W:0]    trial;
        logic [SUM_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;

        // trial = (2*root + 2^k) * 2^k against the running remainder
        always_comb begin
            trial = ({{(SUM_W-ROOT_W){1'b0}}, root_reg[i-1], 1'b0}
                     | ((SUM_W+1)'(1) << K)) << K;
            if ({1'b0, rem_reg[i-1]} >= trial) begin
                rem_next  = rem_reg[i-1] - trial[SUM_W-1:0];
                root_next = root_reg[i-1] | (ROOT_W'(1) << K);
            end else begin
                rem_next  = rem_reg[i-1];
                root_next = root_reg[i-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i]  <= rem_next;
                root_reg[i] <= root_next;
                vec_reg[i]  <= vec_reg[i-1];
            end
        end
    end

    assign out_valid = vld_reg[NSTG-1];
    assign out_data  = vec_reg[ROOT_W];
    assign out_root  = root_reg[ROOT_W];

endmodule
`default_nettype wire

/* rtl/core/tfn_div.sv */
`default_nettype none
module tfn_div (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  en,
    input  wire logic                  in_valid,
    input  wire tfn_pkg::tfn_vec_t     in_data,
    input  wire logic [tfn_pkg::ROOT_W-1:0] in_root,
    output logic                       out_valid,
    output tfn_pkg::tfn_quo_t          out_data
);
    import tfn_pkg::*;

    // stage 0 rounding offset, then one quotient bit per stage in each lane
    localparam int NSTG = QUO_W + 1;

    logic [NSTG-1:0] vld_reg;

    logic [2:0][NUM_W-1:0] rem_reg [QUO_W+1];
    logic [2:0][QUO_W-1:0] q_reg   [QUO_W+1];
    logic [ROOT_W-1:0]     d_reg   [QUO_W+1];
    logic [2:0]            neg_reg [QUO_W+1];
    logic                  dgn_reg [QUO_W+1];
    logic [2:0][NUM_W-1:0] num_next;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            num_next[j] = {in_data.a[j], {NORMAL_FRAC_BITS{1'b0}}}
                        + NUM_W'(in_root >> 1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NSTG-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= num_next;
            q_reg[0]   <= '0;
            d_reg[0]   <= in_root;
            neg_reg[0] <= in_data.neg;
            dgn_reg[0] <= in_data.degen;
        end
    end

    for (genvar i = 1; i <= QUO_W; i++) begin : g_quo
        localparam int K = QUO_W - i;
        logic [NUM_W-1:0]      dsh;
        logic [2:0][NUM_W-1:0] rem_next;
        logic [2:0][QUO_W-1:0] q_next;

        always_comb begin
            dsh = NUM_W'(d_reg[i-1]) << K;
            for (int j = 0; j < 3; j++) begin
                if (rem_reg[i-1][j] >= dsh) begin
                    rem_next[j] = rem_reg[i-1][j] - dsh;
                    q_next[j]   = q_reg[i-1][j] | (QUO_W'(1) << K);
                end else begin
                    rem_next[j] = rem_reg[i-1][j];
                    q_next[j]   = q_reg[i-1][j];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i] <= rem_next;
                q_reg[i]   <= q_next;
                d_reg[i]   <= d_reg[i-1];
                neg_reg[i] <= neg_reg[i-1];
                dgn_reg[i] <= dgn_reg[i-1];
            end
        end
    end

    assign out_valid      = vld_reg[NSTG-1];
    assign out_data.q     = q_reg[QUO_W];
    assign out_data.neg   = neg_reg[QUO_W];
    assign out_data.degen = dgn_reg[QUO_W];

endmodule
`default_nettype wire
